@@ hw/rtl/multi_threshold_silence_finder_top_defines.svh @@
// Assertion macros for the silence finder checker.
`ifndef MULTI_THRESHOLD_SILENCE_FINDER_TOP_DEFINES_SVH
`define MULTI_THRESHOLD_SILENCE_FINDER_TOP_DEFINES_SVH

// same-cycle implication
`define MTSF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtsf checker: same-cycle property failed");

// next-cycle implication
`define MTSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtsf checker: next-cycle property failed");

`endif

@@ hw/rtl/mtsf_pkg.sv @@
package mtsf_pkg;

  localparam int NUM_LEVELS = 30;
  localparam int IDX_W      = $clog2(NUM_LEVELS);
  localparam int LEVEL_MIN  = 100;
  localparam int LEVEL_MAX  = 32767;
  localparam int LEVEL_STEP = (LEVEL_MAX - LEVEL_MIN) / (NUM_LEVELS - 1);

  // floor(x / 1000) for 17-bit x: (x * K_MUL) >> K_SH, exact over the range
  localparam int K_W   = 8;
  localparam int K_MUL = 134218;
  localparam int K_SH  = 27;

  localparam int SIL_W = 22;
  localparam int WS_W  = 28;
  localparam int WE_W  = 29;
  localparam int PAD_W = 22;

  localparam logic [2:0] REG_SAMPLE_RATE = 3'd0;
  localparam logic [2:0] REG_WIN_START   = 3'd1;
  localparam logic [2:0] REG_WIN_LENGTH  = 3'd2;
  localparam logic [2:0] REG_SILENCE     = 3'd3;
  localparam logic [2:0] REG_PAD_AFTER   = 3'd4;
  localparam logic [2:0] REG_PAD_BEFORE  = 3'd5;

  typedef struct packed {
    logic [SIL_W-1:0] sil;
    logic [WS_W-1:0]  ws;
    logic [WE_W-1:0]  we;
    logic [PAD_W-1:0] pa;
    logic [PAD_W-1:0] pb;
  } derived_t;

  typedef struct packed {
    logic             go;
    logic             clr;
    logic             win;
    logic [31:0]      energy;
    logic [31:0]      n;
    logic [SIL_W-1:0] sil;
  } trk_cmd_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [31:0]      start;
  } trk_res_t;

  typedef logic [31:0] thr_tab_t [NUM_LEVELS];

  // 2 * t * t per tracker
  function automatic thr_tab_t mk_thr();
    thr_tab_t tab;
    longint   t;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      t = longint'(LEVEL_MIN) + longint'(i) * longint'(LEVEL_STEP);
      tab[i] = 32'(2 * t * t);
    end
    return tab;
  endfunction

  localparam thr_tab_t THR = mk_thr();

endpackage

@@ hw/rtl/mtsf_cfg.sv @@
module mtsf_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [19:0]       cfg_data,
  output mtsf_pkg::derived_t drv
);

  logic [16:0] sr_r;
  logic [19:0] ws_ms_r;
  logic [19:0] wl_ms_r;
  logic [13:0] sil_ms_r;
  logic [13:0] pa_ms_r;
  logic [13:0] pb_ms_r;

  logic [mtsf_pkg::K_W-1:0] k_r;
  logic [34:0]              k_prod;
  logic [20:0]              we_ms;
  mtsf_pkg::derived_t       drv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r     <= 17'd44100;
      ws_ms_r  <= 20'd0;
      wl_ms_r  <= 20'd10000;
      sil_ms_r <= 14'd1000;
      pa_ms_r  <= 14'd0;
      pb_ms_r  <= 14'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mtsf_pkg::REG_SAMPLE_RATE: sr_r     <= cfg_data[16:0];
        mtsf_pkg::REG_WIN_START:   ws_ms_r  <= cfg_data;
        mtsf_pkg::REG_WIN_LENGTH:  wl_ms_r  <= cfg_data;
        mtsf_pkg::REG_SILENCE:     sil_ms_r <= cfg_data[13:0];
        mtsf_pkg::REG_PAD_AFTER:   pa_ms_r  <= cfg_data[13:0];
        mtsf_pkg::REG_PAD_BEFORE:  pb_ms_r  <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  assign k_prod = 35'(sr_r) * 35'(mtsf_pkg::K_MUL);
  assign we_ms  = 21'(ws_ms_r) + 21'(wl_ms_r);

  // ms to samples: the sample rate passes k_r and then drv_r, the ms registers feed drv_r directly
  always_ff @(posedge clk) begin
    k_r      <= k_prod[mtsf_pkg::K_SH +: mtsf_pkg::K_W];
    drv_r.sil <= mtsf_pkg::SIL_W'(mtsf_pkg::SIL_W'(sil_ms_r) * mtsf_pkg::SIL_W'(k_r));
    drv_r.ws  <= mtsf_pkg::WS_W'(mtsf_pkg::WS_W'(ws_ms_r) * mtsf_pkg::WS_W'(k_r));
    drv_r.we  <= mtsf_pkg::WE_W'(mtsf_pkg::WE_W'(we_ms) * mtsf_pkg::WE_W'(k_r));
    drv_r.pa  <= mtsf_pkg::PAD_W'(mtsf_pkg::PAD_W'(pa_ms_r) * mtsf_pkg::PAD_W'(k_r));
    drv_r.pb  <= mtsf_pkg::PAD_W'(mtsf_pkg::PAD_W'(pb_ms_r) * mtsf_pkg::PAD_W'(k_r));
  end

  assign drv = drv_r;

endmodule

@@ hw/rtl/mtsf_trk.sv @@
module mtsf_trk (
  input  logic               clk,
  input  logic               rst_n,
  input  mtsf_pkg::trk_cmd_t cmd,
  output mtsf_pkg::trk_res_t res
);

  localparam int N = mtsf_pkg::NUM_LEVELS;
  localparam int W = mtsf_pkg::IDX_W;

  logic [63:0]  mem [N];
  logic [N-1:0] vld_r;
  logic [N-1:0] found_r;

  logic [W:0]   rd_cnt_r;
  logic [W-1:0] rd_idx;
  logic         issue;

  logic [63:0]  rd_q_r;
  logic         rv_q_r;
  logic         p_vld_r;
  logic [W-1:0] p_idx_r;

  logic [31:0]  len;
  logic [31:0]  st;
  logic [31:0]  len_new;
  logic [31:0]  st_new;
  logic         quiet;
  logic         fnd_old;
  logic         fset;
  logic         wr_en;
  logic         f_any;

  logic         sel_found_r;
  logic [W-1:0] sel_idx_r;
  logic [31:0]  sel_start_r;

  assign issue  = rd_cnt_r < (W+1)'(N);
  assign rd_idx = rd_cnt_r[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r <= (W+1)'(N);
      p_vld_r  <= 1'b0;
    end else begin
      p_vld_r <= issue && !cmd.go;
      if (cmd.go) begin
        rd_cnt_r <= '0;
      end else if (issue) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_q_r  <= mem[rd_idx];
      rv_q_r  <= vld_r[rd_idx];
      p_idx_r <= rd_idx;
    end
    if (wr_en) begin
      mem[p_idx_r] <= {len_new, st_new};
    end
  end

  // shared update unit, one tracker per cycle
  always_comb begin
    len     = rv_q_r ? rd_q_r[63:32] : 32'd0;
    st      = rv_q_r ? rd_q_r[31:0]  : 32'd0;
    fnd_old = found_r[p_idx_r];
    quiet   = cmd.energy < mtsf_pkg::THR[p_idx_r];
    if (quiet) begin
      len_new = (len == '1) ? len : len + 32'd1;
    end else begin
      len_new = 32'd0;
    end
    st_new = (quiet && len == 32'd0) ? cmd.n : st;
    fset   = quiet && (len >= 32'(cmd.sil));
    wr_en  = p_vld_r && cmd.win && !fnd_old;
    f_any  = fnd_old || (cmd.win && fset);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      vld_r   <= '0;
      found_r <= '0;
    end else if (wr_en) begin
      vld_r[p_idx_r]   <= 1'b1;
      found_r[p_idx_r] <= fset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_found_r <= 1'b0;
      sel_idx_r   <= '0;
    end else if (cmd.go) begin
      sel_found_r <= 1'b0;
      sel_idx_r   <= '0;
    end else if (p_vld_r && f_any && !sel_found_r) begin
      sel_found_r <= 1'b1;
      sel_idx_r   <= p_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p_vld_r && f_any && !sel_found_r) begin
      sel_start_r <= st_new;
    end
  end

  assign res.done  = p_vld_r && (p_idx_r == W'(N - 1));
  assign res.found = sel_found_r;
  assign res.idx   = sel_idx_r;
  assign res.start = sel_start_r;

endmodule

@@ hw/rtl/multi_threshold_silence_finder_top.sv @@
// Silence finder over a mono 16-bit PCM stream.
// Input words carry one sample each on in_tdata; in_tlast marks the final
// sample of a stream. Only a word with in_tlast produces a result word on the
// out_ channel; other words produce nothing.
// Configuration writes (cfg_index, cfg_data) are taken in any cycle.
// Each sample keeps the block busy through S_SQ0 and S_SQ1 on the shared
// squarer, S_WALK to start the tracker walk and make the first memory read,
// and then one level per cycle through the tracker update unit. in_tready
// returns the cycle after the last level, so a new word is taken only once
// the previous sample is through. A last word then passes S_MID and S_FIN
// for the cut-point adds before the result is registered.
// in_tready is high only when the sequencer is idle; the block then takes the
// next word even while a result waits. If the receiver stalls, the finished
// result waits in the output register and the next last word waits until that
// slot is taken. After the result is loaded all tracker state and the sample
// count clear. Reset (rst_n low, synchronous) restores the register defaults,
// clears the trackers at once through their valid bits and drops out_tvalid.
module multi_threshold_silence_finder_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // [15:0] sample
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // [4:0] level_index, [36:5] silence_start,
                                   // [70:37] cut_end_sample,
                                   // [104:71] cut_start_sample, rest zero
  output logic [0:0]   out_tuser,  // [0] found
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [19:0]  cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ0  = 3'd1;
  localparam logic [2:0] S_SQ1  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_MID  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  mtsf_pkg::derived_t drv;
  mtsf_pkg::trk_cmd_t cmd;
  mtsf_pkg::trk_res_t res;

  logic signed [15:0] cur_r;
  logic signed [15:0] prev_r;
  logic               last_r;
  logic [31:0]        cnt_r;
  logic               go_r;
  logic signed [15:0] mul_a;
  logic signed [31:0] sq;
  logic [31:0]        sq_r;
  logic [31:0]        energy_r;
  logic [31:0]        start_sel;
  logic [31:0]        start_r;
  logic [33:0]        mid_r;
  logic               fin_load;
  logic               accept;

  logic               out_vld_r;
  logic               o_found_r;
  logic [4:0]         o_lvl_r;
  logic [31:0]        o_start_r;
  logic [33:0]        o_end_r;
  logic [33:0]        o_cut_r;

  mtsf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .drv       (drv)
  );

  mtsf_trk u_trk (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .res   (res)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign fin_load  = (state_r == S_FIN) && (!out_vld_r || out_tready);

  assign mul_a = (state_r == S_SQ0) ? cur_r : prev_r;
  assign sq    = mul_a * mul_a;

  assign start_sel = res.found ? res.start : {1'b0, cnt_r[31:1]};

  always_comb begin
    cmd.go     = go_r;
    cmd.clr    = fin_load;
    cmd.win    = (cnt_r > 32'(drv.ws)) && (cnt_r < 32'(drv.we));
    cmd.energy = energy_r;
    cmd.n      = cnt_r;
    cmd.sil    = drv.sil;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_SQ0;
      S_SQ0:  state_nxt = S_SQ1;
      S_SQ1:  state_nxt = S_WALK;
      S_WALK: if (res.done) state_nxt = last_r ? S_MID : S_IDLE;
      S_MID:  state_nxt = S_FIN;
      S_FIN:  if (fin_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      go_r      <= 1'b0;
      cnt_r     <= 32'd0;
      prev_r    <= 16'sd0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= (state_r == S_SQ1);
      if (state_r == S_WALK && res.done) begin
        cnt_r  <= cnt_r + 32'd1;
        prev_r <= cur_r;
      end else if (fin_load) begin
        cnt_r  <= 32'd0;
        prev_r <= 16'sd0;
      end
      if (fin_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r  <= $signed(in_tdata);
      last_r <= in_tlast;
    end
    if (state_r == S_SQ0) begin
      sq_r <= $unsigned(sq);
    end
    if (state_r == S_SQ1) begin
      energy_r <= sq_r + $unsigned(sq);
    end
    if (state_r == S_MID) begin
      start_r <= start_sel;
      mid_r   <= 34'(start_sel) + 34'(drv.sil[mtsf_pkg::SIL_W-1:1]);
    end
    if (fin_load) begin
      o_found_r <= res.found;
      o_lvl_r   <= 5'(res.idx);
      o_start_r <= start_r;
      o_end_r   <= mid_r + 34'(drv.pa);
      o_cut_r   <= mid_r - 34'(drv.pb);
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = {7'd0, o_cut_r, o_end_r, o_start_r, o_lvl_r};
  assign out_tuser[0] = o_found_r;

endmodule

@@ hw/rtl/mtsf_chk.sv @@
`include "multi_threshold_silence_finder_top_defines.svh"

module mtsf_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata,
  input logic [0:0]   out_tuser
);

  `MTSF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  `MTSF_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  `MTSF_ASSERT_NOW(a_idx_zero_when_none, out_tvalid && !out_tuser[0], out_tdata[4:0] == 5'd0)

  `MTSF_ASSERT_NOW(a_cut_order, out_tvalid, $signed(out_tdata[70:37]) >= $signed(out_tdata[104:71]))

endmodule

bind multi_threshold_silence_finder_top mtsf_chk u_mtsf_chk (.*);
